@@ hw/rtl/f32rem_pkg.sv @@
// Shared types, constants and helper functions for the binary32 remainder pipeline.
`timescale 1ns / 1ps
`default_nettype none

package f32rem_pkg;

	// 24 quotient bits plus one round bit, one bit per stage
	localparam int DIV_STEPS = 25;
	// fixed-point window for the exact x - q*y difference
	localparam int WIN_W = 74;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

	typedef logic signed [9:0] exp_t;

	typedef enum logic [2:0] {
		KIND_NORM,
		KIND_NAN,
		KIND_INV,
		KIND_INF,
		KIND_XPASS
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        sx;
		logic [23:0] mx;
		logic [23:0] my;
		exp_t        ex;
		exp_t        ey;
		exp_t        eq;
		logic [31:0] xbits;
		logic [24:0] rem;
		logic [24:0] qb;
	} div_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [6:0] lzc_win(input logic [WIN_W-1:0] v);
		logic [6:0] n;
		n = 7'(WIN_W);
		for (int i = 0; i < WIN_W; i++) begin
			if (v[i]) n = 7'(WIN_W - 1 - i);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/float32_remainder_unit.sv @@
// Pipelined binary32 remainder: x - round_int(fl32(x/y)) * y, double rounded to binary32.
// Throughput: one request per cycle; one restoring-division bit per stage sets the depth.
// The whole pipeline holds while a finished result is not taken.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers keep no reset.
`timescale 1ns / 1ps
`default_nettype none

module float32_remainder_unit import f32rem_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [31:0] x_bits,
	input  wire  [31:0] y_bits,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] rem_bits,
	output logic        invalid
);

	logic en;
	assign en = ~out_valid | out_ready;
	assign in_ready = en;

	// ---------------- stage 1: unpack, classify, normalize ----------------
	logic [7:0]  x_ef, y_ef;
	logic [23:0] manx, many;
	logic [4:0]  lzx, lzy;
	logic        x_inf, x_nan, x_zero, y_inf, y_nan, y_zero;
	kind_t       kind_c1;

	assign x_ef = x_bits[30:23];
	assign y_ef = y_bits[30:23];
	assign manx = {x_ef != 8'd0, x_bits[22:0]};
	assign many = {y_ef != 8'd0, y_bits[22:0]};
	assign lzx = lzc24(manx);
	assign lzy = lzc24(many);
	assign x_inf  = (x_ef == 8'hFF) && (x_bits[22:0] == 23'd0);
	assign x_nan  = (x_ef == 8'hFF) && (x_bits[22:0] != 23'd0);
	assign x_zero = (x_bits[30:0] == 31'd0);
	assign y_inf  = (y_ef == 8'hFF) && (y_bits[22:0] == 23'd0);
	assign y_nan  = (y_ef == 8'hFF) && (y_bits[22:0] != 23'd0);
	assign y_zero = (y_bits[30:0] == 31'd0);

	always_comb begin
		if (x_inf || y_zero) begin
			kind_c1 = KIND_INV;
		end else if (x_nan || y_nan || y_inf) begin
			kind_c1 = KIND_NAN;
		end else if (x_zero) begin
			kind_c1 = KIND_XPASS;
		end else begin
			kind_c1 = KIND_NORM;
		end
	end

	logic        v_s1;
	kind_t       kind_s1;
	logic        sx_s1;
	logic [23:0] mx_s1, my_s1;
	exp_t        ex_s1, ey_s1;
	logic [31:0] xbits_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= kind_c1;
			sx_s1    <= x_bits[31];
			mx_s1    <= manx << lzx;
			my_s1    <= many << lzy;
			ex_s1    <= ((x_ef == 8'd0) ? -10'sd126 : exp_t'({2'b0, x_ef}) - 10'sd127)
				- exp_t'({5'b0, lzx});
			ey_s1    <= ((y_ef == 8'd0) ? -10'sd126 : exp_t'({2'b0, y_ef}) - 10'sd127)
				- exp_t'({5'b0, lzy});
			xbits_s1 <= x_bits;
		end
	end

	// ---------------- division stages: one quotient bit each ----------------
	div_t                 div_first;
	div_t                 div_nx [DIV_STEPS];
	div_t                 div_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] div_v_s;
	logic                 ge_c;

	assign ge_c = mx_s1 >= my_s1;

	always_comb begin
		div_first.kind  = kind_s1;
		div_first.sx    = sx_s1;
		div_first.mx    = mx_s1;
		div_first.my    = my_s1;
		div_first.ex    = ex_s1;
		div_first.ey    = ey_s1;
		div_first.eq    = ge_c ? ex_s1 - ey_s1 : ex_s1 - ey_s1 - 10'sd1;
		div_first.xbits = xbits_s1;
		// start with the partial remainder scaled so the quotient lands in [1,2)
		div_first.rem   = ge_c ? {1'b0, mx_s1} : {mx_s1, 1'b0};
		div_first.qb    = '0;
	end

	always_comb begin
		div_t        cur;
		logic [24:0] trial;
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (j == 0) begin
				cur = div_first;
			end else begin
				cur = div_s[j-1];
			end
			trial = cur.rem - {1'b0, cur.my};
			div_nx[j] = cur;
			if (cur.rem >= {1'b0, cur.my}) begin
				div_nx[j].rem = {trial[23:0], 1'b0};
				div_nx[j].qb  = {cur.qb[23:0], 1'b1};
			end else begin
				div_nx[j].rem = {cur.rem[23:0], 1'b0};
				div_nx[j].qb  = {cur.qb[23:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s <= '0;
		end else if (en) begin
			div_v_s <= {div_v_s[DIV_STEPS-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_STEPS; j++) begin
				div_s[j] <= div_nx[j];
			end
		end
	end

	// ---------------- stage 3: round quotient to binary32 ----------------
	div_t        dl;
	logic [24:0] qsum_c;
	exp_t        qe_c;
	kind_t       kind_c3;

	assign dl = div_s[DIV_STEPS-1];
	assign qsum_c = {1'b0, dl.qb[24:1]} + 25'(dl.qb[0] & ((|dl.rem) | dl.qb[1]));
	assign qe_c = qsum_c[24] ? dl.eq + 10'sd1 : dl.eq;

	always_comb begin
		kind_c3 = dl.kind;
		if (dl.kind == KIND_NORM) begin
			if (qe_c > 10'sd127) begin
				kind_c3 = KIND_INF;
			end else if (qe_c < -10'sd1) begin
				// |q| below one half: integer quotient is zero, result is x
				kind_c3 = KIND_XPASS;
			end
		end
	end

	logic        v_s3;
	kind_t       kind_s3;
	logic        sx_s3;
	logic [23:0] qsig_s3, mx_s3, my_s3;
	exp_t        qe_s3, ex_s3, ey_s3;
	logic [31:0] xbits_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= div_v_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3  <= kind_c3;
			sx_s3    <= dl.sx;
			qsig_s3  <= qsum_c[24] ? 24'h80_0000 : qsum_c[23:0];
			qe_s3    <= qe_c;
			mx_s3    <= dl.mx;
			my_s3    <= dl.my;
			ex_s3    <= dl.ex;
			ey_s3    <= dl.ey;
			xbits_s3 <= dl.xbits;
		end
	end

	// ---------------- stage 4: round quotient to integer ----------------
	logic        big_c;
	exp_t        shd_c, qs_c, kk_c;
	logic [47:0] ext4_c;
	logic [23:0] nint_c;
	kind_t       kind_c4;

	assign big_c = qe_s3 >= 10'sd23;
	assign shd_c = 10'sd23 - qe_s3;
	assign ext4_c = {qsig_s3, 24'd0} >> shd_c[4:0];
	assign nint_c = ext4_c[47:24] + 24'(ext4_c[23] & ((|ext4_c[22:0]) | ext4_c[24]));
	assign qs_c = big_c ? qe_s3 - 10'sd23 : 10'sd0;
	// offset of the product LSB against the aligned x LSB
	assign kk_c = 10'sd24 + qs_c + ey_s3 - ex_s3;

	always_comb begin
		kind_c4 = kind_s3;
		if (kind_s3 == KIND_NORM && !big_c && nint_c == 24'd0) begin
			kind_c4 = KIND_XPASS;
		end
	end

	logic        v_s4;
	kind_t       kind_s4;
	logic        sx_s4;
	logic [23:0] q_s4, mx_s4, my_s4;
	logic [4:0]  k_s4;
	exp_t        ex_s4;
	logic [31:0] xbits_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4  <= kind_c4;
			sx_s4    <= sx_s3;
			q_s4     <= big_c ? qsig_s3 : nint_c;
			k_s4     <= kk_c[4:0];
			mx_s4    <= mx_s3;
			my_s4    <= my_s3;
			ex_s4    <= ex_s3;
			xbits_s4 <= xbits_s3;
		end
	end

	// ---------------- stage 5: exact product q*y ----------------
	logic        v_s5;
	kind_t       kind_s5;
	logic        sx_s5;
	logic [47:0] prod_s5;
	logic [4:0]  k_s5;
	logic [23:0] mx_s5;
	exp_t        ex_s5;
	logic [31:0] xbits_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5  <= kind_s4;
			sx_s5    <= sx_s4;
			prod_s5  <= q_s4 * my_s4;
			k_s5     <= k_s4;
			mx_s5    <= mx_s4;
			ex_s5    <= ex_s4;
			xbits_s5 <= xbits_s4;
		end
	end

	// ---------------- stage 6: exact difference in a fixed window ----------------
	logic [WIN_W-1:0] a_c, b_c;

	assign a_c = WIN_W'({mx_s5, 24'd0});
	assign b_c = WIN_W'(prod_s5) << k_s5;

	logic             v_s6;
	kind_t            kind_s6;
	logic             sx_s6;
	logic [WIN_W:0]   diff_s6;
	exp_t             ex_s6;
	logic [31:0]      xbits_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s6  <= kind_s5;
			sx_s6    <= sx_s5;
			diff_s6  <= {1'b0, a_c} - {1'b0, b_c};
			ex_s6    <= ex_s5;
			xbits_s6 <= xbits_s5;
		end
	end

	// ---------------- stage 7: magnitude and sign ----------------
	logic             v_s7;
	kind_t            kind_s7;
	logic             sx_s7, sign_s7;
	logic [WIN_W-1:0] mag_s7;
	exp_t             ex_s7;
	logic [31:0]      xbits_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s7  <= kind_s6;
			sx_s7    <= sx_s6;
			sign_s7  <= sx_s6 ^ diff_s6[WIN_W];
			mag_s7   <= diff_s6[WIN_W] ? WIN_W'(0) - diff_s6[WIN_W-1:0] : diff_s6[WIN_W-1:0];
			ex_s7    <= ex_s6;
			xbits_s7 <= xbits_s6;
		end
	end

	// ---------------- stage 8: leading zero count ----------------
	logic             v_s8;
	kind_t            kind_s8;
	logic             sx_s8, sign_s8;
	logic [WIN_W-1:0] mag_s8;
	logic [6:0]       lz_s8;
	exp_t             ex_s8;
	logic [31:0]      xbits_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s8  <= kind_s7;
			sx_s8    <= sx_s7;
			sign_s8  <= sign_s7;
			mag_s8   <= mag_s7;
			lz_s8    <= lzc_win(mag_s7);
			ex_s8    <= ex_s7;
			xbits_s8 <= xbits_s7;
		end
	end

	// ---------------- stage 9: normalize ----------------
	logic             v_s9;
	kind_t            kind_s9;
	logic             sx_s9, sign_s9;
	logic [WIN_W-1:0] nm_s9;
	exp_t             e_s9;
	logic [31:0]      xbits_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s9  <= kind_s8;
			sx_s9    <= sx_s8;
			sign_s9  <= sign_s8;
			nm_s9    <= mag_s8 << lz_s8;
			// window LSB weighs 2^(ex-47); exponent of the leading bit
			e_s9     <= ex_s8 + exp_t'(WIN_W - 48) - exp_t'({3'b0, lz_s8});
			xbits_s9 <= xbits_s8;
		end
	end

	// ---------------- stage 10: round to binary64 precision ----------------
	logic [53:0] sum53_c;

	assign sum53_c = {1'b0, nm_s9[WIN_W-1 -: 53]}
		+ 54'(nm_s9[WIN_W-54] & ((|nm_s9[WIN_W-55:0]) | nm_s9[WIN_W-53]));

	logic        v_s10;
	kind_t       kind_s10;
	logic        sx_s10, sign_s10, zero_s10;
	logic [52:0] m53_s10;
	exp_t        e_s10;
	logic [31:0] xbits_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s10  <= kind_s9;
			sx_s10    <= sx_s9;
			sign_s10  <= sign_s9;
			zero_s10  <= ~nm_s9[WIN_W-1];
			m53_s10   <= sum53_c[53] ? {1'b1, 52'd0} : sum53_c[52:0];
			e_s10     <= sum53_c[53] ? e_s9 + 10'sd1 : e_s9;
			xbits_s10 <= xbits_s9;
		end
	end

	// ---------------- stage 11: round to binary32 and pack ----------------
	logic [24:0]  s25_c;
	exp_t         e_nrm_c, bexp_c, sft_c;
	logic         ovf_c, deep_c, is_sub_c, res_zero_c;
	logic [31:0]  nrm_bits_c, norm_res_c;
	logic [107:0] ext11_c;
	logic [23:0]  sub_n_c;

	assign s25_c = {1'b0, m53_s10[52:29]}
		+ 25'(m53_s10[28] & ((|m53_s10[27:0]) | m53_s10[29]));
	assign e_nrm_c = s25_c[24] ? e_s10 + 10'sd1 : e_s10;
	assign ovf_c = e_nrm_c > 10'sd127;
	assign bexp_c = e_nrm_c + 10'sd127;
	assign nrm_bits_c = ovf_c ? {sign_s10, 8'hFF, 23'd0}
		: {sign_s10, bexp_c[7:0], s25_c[24] ? 23'd0 : s25_c[22:0]};

	// subnormal: round the binary64 value to a multiple of 2^-149
	assign sft_c = -10'sd97 - e_s10;
	assign deep_c = sft_c > 10'sd54;
	assign ext11_c = {m53_s10, 55'd0} >> sft_c[5:0];
	assign sub_n_c = ext11_c[78:55] + 24'(ext11_c[54] & ((|ext11_c[53:0]) | ext11_c[55]));
	assign is_sub_c = e_s10 < -10'sd126;
	assign res_zero_c = zero_s10 | (is_sub_c & (deep_c | (sub_n_c == 24'd0)));

	always_comb begin
		if (res_zero_c) begin
			norm_res_c = {sx_s10, 31'd0};
		end else if (is_sub_c) begin
			norm_res_c = {sign_s10, 7'd0, sub_n_c};
		end else begin
			norm_res_c = nrm_bits_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			invalid <= (kind_s10 == KIND_INV);
			case (kind_s10)
				KIND_NORM: begin
					rem_bits <= norm_res_c;
				end
				KIND_INF: begin
					// quotient overflowed: x - inf*y is infinite, opposite to x
					rem_bits <= {~sx_s10, 8'hFF, 23'd0};
				end
				KIND_XPASS: begin
					rem_bits <= xbits_s10;
				end
				default: begin
					rem_bits <= QNAN_BITS;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
